@@ src/spq_pkg.sv @@
// spq_pkg: shared types, codes and defaults for the sorted priority queue
// used by spq_ctrl, spq_dpath and sorted_priority_queue_top; no dependencies
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int KEY_BITS    = 8;

  // action codes
  localparam logic [1:0] ACT_ENQ  = 2'd0;
  localparam logic [1:0] ACT_DEQ  = 2'd1;
  localparam logic [1:0] ACT_PEEK = 2'd2;

  // status codes
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_EMPTY = 2'd1;
  localparam logic [1:0] STS_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] entry_code;
    logic [15:0] entry_name;
    logic [7:0]  entry_key;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        head_valid;
    logic [15:0] head_code;
    logic [15:0] head_name;
    logic [7:0]  head_key;
    logic [4:0]  occupancy;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic       enq;
    logic       deq;
    logic       load;
    logic       show_head;
    logic [1:0] status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
  } stat_t;

endpackage

@@ src/spq_ctrl.sv @@
// spq_ctrl: handshake control and command decode for the sorted priority queue
// depends on spq_pkg
module spq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        action_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  spq_pkg::stat_t    stat_i,
  output spq_pkg::cmd_t     cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_HOLD = 1'b1;

  logic state_q, state_d;
  logic accept;

  // result register drains or is empty -> take a new word
  assign in_stall_o  = (state_q == ST_HOLD) && out_stall_i;
  assign out_valid_o = (state_q == ST_HOLD);
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o = '0;
    cmd_o.load   = accept;
    cmd_o.status = spq_pkg::STS_OK;
    if (accept) begin
      unique case (action_i)
        spq_pkg::ACT_ENQ: begin
          if (stat_i.full) cmd_o.status = spq_pkg::STS_FULL;
          else             cmd_o.enq    = 1'b1;
        end
        spq_pkg::ACT_DEQ, spq_pkg::ACT_PEEK: begin
          if (stat_i.empty) begin
            cmd_o.status = spq_pkg::STS_EMPTY;
          end else begin
            cmd_o.show_head = 1'b1;
            cmd_o.deq       = (action_i == spq_pkg::ACT_DEQ);
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    if (accept) state_d = ST_HOLD;
    else if (state_q == ST_HOLD && !out_stall_i) state_d = ST_IDLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

endmodule

@@ src/spq_dpath.sv @@
// spq_dpath: sorted slot row with parallel compare and shift, plus result register
// depends on spq_pkg
module spq_dpath #(
  parameter int QueueDepth = spq_pkg::QUEUE_DEPTH,
  parameter int KeyBits    = spq_pkg::KEY_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spq_pkg::cmd_t       cmd_i,
  input  spq_pkg::in_word_t   in_word_i,
  output spq_pkg::stat_t      stat_o,
  output spq_pkg::out_word_t  out_word_o
);

  localparam int CntW = $clog2(QueueDepth + 1);

  logic [15:0]      code_q [QueueDepth];
  logic [15:0]      name_q [QueueDepth];
  logic [KeyBits-1:0] key_q [QueueDepth];
  logic [15:0]      code_d [QueueDepth];
  logic [15:0]      name_d [QueueDepth];
  logic [KeyBits-1:0] key_d [QueueDepth];

  logic [CntW-1:0]  count_q, count_d;
  logic [QueueDepth-1:0] ge;
  logic [KeyBits-1:0] new_key;
  spq_pkg::out_word_t res_q;
  logic [31:0]      occ_ext;
  logic [31:0]      key_ext;

  assign new_key = KeyBits'(in_word_i.entry_key);

  // held slots whose key is >= the new key; a prefix since the row is sorted
  always_comb begin
    for (int i = 0; i < QueueDepth; i++) begin
      ge[i] = (CntW'(i) < count_q) && (key_q[i] >= new_key);
    end
  end

  for (genvar g = 0; g < QueueDepth; g++) begin : g_slot
    always_comb begin
      code_d[g] = code_q[g];
      name_d[g] = name_q[g];
      key_d[g]  = key_q[g];
      if (cmd_i.enq && !ge[g]) begin
        if (g == 0) begin
          code_d[g] = in_word_i.entry_code;
          name_d[g] = in_word_i.entry_name;
          key_d[g]  = new_key;
        end else begin
          if (ge[(g == 0) ? 0 : g-1]) begin
            code_d[g] = in_word_i.entry_code;
            name_d[g] = in_word_i.entry_name;
            key_d[g]  = new_key;
          end else begin
            code_d[g] = code_q[(g == 0) ? 0 : g-1];
            name_d[g] = name_q[(g == 0) ? 0 : g-1];
            key_d[g]  = key_q[(g == 0) ? 0 : g-1];
          end
        end
      end else if (cmd_i.deq && g < QueueDepth - 1) begin
        code_d[g] = code_q[(g < QueueDepth - 1) ? g+1 : g];
        name_d[g] = name_q[(g < QueueDepth - 1) ? g+1 : g];
        key_d[g]  = key_q[(g < QueueDepth - 1) ? g+1 : g];
      end
    end

    always_ff @(posedge clk_i) begin
      code_q[g] <= code_d[g];
      name_q[g] <= name_d[g];
      key_q[g]  <= key_d[g];
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.enq)      count_d = count_q + CntW'(1);
    else if (cmd_i.deq) count_d = count_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) count_q <= '0;
    else         count_q <= count_d;
  end

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CntW'(QueueDepth));

  assign occ_ext = 32'(count_d);
  assign key_ext = 32'(key_q[0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_q.status     <= cmd_i.status;
      res_q.head_valid <= cmd_i.show_head;
      res_q.head_code  <= cmd_i.show_head ? code_q[0] : 16'd0;
      res_q.head_name  <= cmd_i.show_head ? name_q[0] : 16'd0;
      res_q.head_key   <= cmd_i.show_head ? key_ext[7:0] : 8'd0;
      res_q.occupancy  <= occ_ext[4:0];
    end
  end

  assign out_word_o = res_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("fill count above depth");

  a_enq_deq_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.enq && cmd_i.deq))
    else $error("enqueue and dequeue together");

  a_enq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.enq |=> count_q == $past(count_q) + CntW'(1))
    else $error("enqueue did not advance fill count");

  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CntW'(2)) |-> (key_q[0] >= key_q[1]))
    else $error("head key below second key");

endmodule

@@ src/sorted_priority_queue_top.sv @@
// a result word is registered and valid in the cycle after its request word is accepted
// throughput: one word per cycle while the receiver does not stall; the slot row compares every slot to the new key
//   in parallel and shifts in the same cycle, and the result register frees as it drains
// reset: rst_ni async active low clears the fill count and handshake state;
//   slot contents are not cleared, only slots below the fill count are read
// depends on spq_pkg, spq_ctrl, spq_dpath
module sorted_priority_queue_top #(
  parameter int QueueDepth = spq_pkg::QUEUE_DEPTH,
  parameter int KeyBits    = spq_pkg::KEY_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  spq_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output spq_pkg::out_word_t out_word_o
);

  spq_pkg::cmd_t  cmd;
  spq_pkg::stat_t stat;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (in_word_i.action),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  spq_dpath #(
    .QueueDepth (QueueDepth),
    .KeyBits    (KeyBits)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_word_i  (in_word_i),
    .stat_o     (stat),
    .out_word_o (out_word_o)
  );

endmodule

@@ sim/spq_tb_pkg.sv @@
`timescale 1ns / 1ps
// spq_tb_pkg: expected-result predictor and scoreboard for the sorted priority queue
// depends on spq_pkg for the word types, action and status codes and the queue size
package spq_tb_pkg;

  // action code the block ignores
  localparam logic [1:0] ACT_IGNORED = 2'd3;

  class head_order_model;
    typedef struct packed {
      logic [15:0]                  code;
      logic [15:0]                  name;
      logic [spq_pkg::KEY_BITS-1:0] key;
    } held_entry_t;

    held_entry_t        slots[spq_pkg::QUEUE_DEPTH];
    int unsigned        fill = 0;
    spq_pkg::out_word_t pending_replies[$];
    int unsigned        errors = 0;
    int unsigned        checked = 0;
    int unsigned        full_drops = 0;
    int unsigned        empty_reads = 0;
    int unsigned        peak_fill = 0;

    function spq_pkg::out_word_t predict_reply(spq_pkg::in_word_t w);
      spq_pkg::out_word_t r;
      int unsigned pos;
      r = '0;
      case (w.action)
        spq_pkg::ACT_ENQ: begin
          if (fill >= spq_pkg::QUEUE_DEPTH) begin
            r.status = spq_pkg::STS_FULL;
            full_drops++;
          end else begin
            // new entry goes behind every entry with an equal or larger key
            pos = 0;
            while (pos < fill && slots[pos].key >= w.entry_key[spq_pkg::KEY_BITS-1:0]) pos++;
            for (int i = fill; i > pos; i--) slots[i] = slots[i-1];
            slots[pos].code = w.entry_code;
            slots[pos].name = w.entry_name;
            slots[pos].key  = w.entry_key[spq_pkg::KEY_BITS-1:0];
            fill++;
            if (fill > peak_fill) peak_fill = fill;
          end
        end
        spq_pkg::ACT_DEQ, spq_pkg::ACT_PEEK: begin
          if (fill == 0) begin
            r.status = spq_pkg::STS_EMPTY;
            empty_reads++;
          end else begin
            r.head_valid = 1'b1;
            r.head_code  = slots[0].code;
            r.head_name  = slots[0].name;
            r.head_key   = 8'(slots[0].key);
            if (w.action == spq_pkg::ACT_DEQ) begin
              for (int i = 0; i + 1 < fill; i++) slots[i] = slots[i+1];
              fill--;
            end
          end
        end
        default: ;
      endcase
      r.occupancy = 5'(fill);
      return r;
    endfunction

    function void note_request(spq_pkg::in_word_t w);
      pending_replies.push_back(predict_reply(w));
    endfunction

    function int unsigned pending();
      return pending_replies.size();
    endfunction

    function void check_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
    endfunction

    function void check_reply(spq_pkg::out_word_t got);
      spq_pkg::out_word_t want;
      if (pending_replies.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing expected, expected none, actual %h",
                 $time, got);
        return;
      end
      want = pending_replies.pop_front();
      checked++;
      check_field("status", 16'(want.status), 16'(got.status));
      check_field("head_valid", 16'(want.head_valid), 16'(got.head_valid));
      check_field("head_code", want.head_code, got.head_code);
      check_field("head_name", want.head_name, got.head_name);
      check_field("head_key", 16'(want.head_key), 16'(got.head_key));
      check_field("occupancy", 16'(want.occupancy), 16'(got.occupancy));
    endfunction
  endclass

endpackage

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// testbench: directed and random enqueue, dequeue and peek traffic for
// sorted_priority_queue_top with random stalls; depends on spq_pkg and spq_tb_pkg
module testbench;

  localparam int unsigned RANDOM_WORDS = 900;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned LONG_HOLD    = 150;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  spq_pkg::in_word_t  in_word_i   = '0;
  logic               out_stall_i = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  spq_pkg::out_word_t out_word_o;

  spq_tb_pkg::head_order_model board = new();

  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;
  int unsigned rx_hold = 0;
  int unsigned words_sent = 0;
  int unsigned cycle_count = 0;

  sorted_priority_queue_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic spq_pkg::in_word_t make_word(logic [1:0] action, logic [15:0] code,
                                                  logic [15:0] name, logic [7:0] key);
    spq_pkg::in_word_t w;
    w.action     = action;
    w.entry_code = code;
    w.entry_name = name;
    w.entry_key  = key;
    return w;
  endfunction

  function automatic spq_pkg::in_word_t random_word(int unsigned enq_pct);
    spq_pkg::in_word_t w;
    int unsigned       roll;
    roll         = $urandom_range(0, 99);
    w.entry_code = 16'($urandom);
    w.entry_name = 16'($urandom);
    // half the keys come from four values so ties are common
    w.entry_key  = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, 3) * 85);
    if (roll < 3) w.action = spq_tb_pkg::ACT_IGNORED;
    else if (roll < 3 + enq_pct) w.action = spq_pkg::ACT_ENQ;
    else if ($urandom_range(0, 3) == 0) w.action = spq_pkg::ACT_PEEK;
    else w.action = spq_pkg::ACT_DEQ;
    return w;
  endfunction

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_word(input spq_pkg::in_word_t w);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    board.note_request(w);
    words_sent++;
    @(negedge clk_i);
  endtask

  // called at a falling edge right after a send, so the last word is withdrawn first
  task automatic wait_all_replies();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // receiver: random stall before each result word, long holds on request
  initial begin
    int unsigned hold;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
      if (rx_hold != 0) begin
        hold    = rx_hold;
        rx_hold = 0;
      end else begin
        hold = rx_burst ? 0 : $urandom_range(0, 15);
      end
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      board.check_reply(out_word_o);
      @(negedge clk_i);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    int unsigned enq_pct;
    enq_pct = 50;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty queue: peek, dequeue, ignored action
    send_word(make_word(spq_pkg::ACT_PEEK, 16'h0000, 16'h0000, 8'd0));
    send_word(make_word(spq_pkg::ACT_DEQ, 16'hffff, 16'hffff, 8'd255));
    send_word(make_word(spq_tb_pkg::ACT_IGNORED, 16'h1234, 16'h5678, 8'd9));
    // fill to capacity with extreme keys and ties
    send_word(make_word(spq_pkg::ACT_ENQ, 16'h0000, 16'h0000, 8'd0));
    send_word(make_word(spq_pkg::ACT_ENQ, 16'hffff, 16'hffff, 8'd255));
    send_word(make_word(spq_pkg::ACT_ENQ, 16'h0001, 16'h8000, 8'd255));
    send_word(make_word(spq_pkg::ACT_ENQ, 16'h8000, 16'h0001, 8'd0));
    send_word(make_word(spq_pkg::ACT_ENQ, 16'h5555, 16'haaaa, 8'd128));
    send_word(make_word(spq_pkg::ACT_ENQ, 16'haaaa, 16'h5555, 8'd127));
    send_word(make_word(spq_pkg::ACT_ENQ, 16'h00ff, 16'hff00, 8'd1));
    send_word(make_word(spq_pkg::ACT_ENQ, 16'hff00, 16'h00ff, 8'd254));
    send_word(make_word(spq_pkg::ACT_ENQ, 16'h0f0f, 16'hf0f0, 8'd128));
    send_word(make_word(spq_pkg::ACT_ENQ, 16'hf0f0, 16'h0f0f, 8'd255));
    send_word(make_word(spq_pkg::ACT_ENQ, 16'h3333, 16'hcccc, 8'd64));
    send_word(make_word(spq_pkg::ACT_ENQ, 16'hcccc, 16'h3333, 8'd0));
    send_word(make_word(spq_pkg::ACT_ENQ, 16'h7fff, 16'h7fff, 8'd200));
    send_word(make_word(spq_pkg::ACT_ENQ, 16'h8001, 16'h8001, 8'd1));
    send_word(make_word(spq_pkg::ACT_ENQ, 16'h1111, 16'heeee, 8'd128));
    send_word(make_word(spq_pkg::ACT_ENQ, 16'heeee, 16'h1111, 8'd127));
    // full: dropped enqueue, ignored action, then read the head
    send_word(make_word(spq_pkg::ACT_ENQ, 16'hdead, 16'hbeef, 8'd255));
    send_word(make_word(spq_tb_pkg::ACT_IGNORED, 16'hffff, 16'hffff, 8'd255));
    send_word(make_word(spq_pkg::ACT_PEEK, 16'h0000, 16'h0000, 8'd0));
    send_word(make_word(spq_pkg::ACT_DEQ, 16'h0000, 16'h0000, 8'd0));

    // receiver holds off while words keep coming, so the input backs up
    wait_all_replies();
    rx_hold  = LONG_HOLD;
    tx_burst = 1'b1;
    repeat (24) send_word(random_word(85));
    tx_burst = 1'b0;
    wait_all_replies();

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: enq_pct = 20;
          1: enq_pct = 55;
          default: enq_pct = 85;
        endcase
        tx_burst = ($urandom_range(0, 3) == 0);
      end
      if (n == RANDOM_WORDS / 2) wait_all_replies();
      send_word(random_word(enq_pct));
    end
    in_valid_i <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("summary: %0d request words sent, %0d result words checked",
             words_sent, board.checked);
    $display("summary: %0d drops on a full queue, %0d reads of an empty queue, peak fill %0d",
             board.full_drops, board.empty_reads, board.peak_fill);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
